// ----- sv/poi_pkg.sv -----
// poi_pkg: shared constants and types for the planar odometry integrator.
// No dependencies.
package poi_pkg;
	localparam int CordicStepsDefault   = 16;
	localparam int FractionBitsDefault  = 16;
	localparam int TableLen             = 24;
	localparam logic signed [31:0] CordicK  = 32'sd652032875;
	localparam logic [29:0] RadToBam        = 30'd683565276;
	localparam logic [17:0] LinearGainReset = 18'd65536;
	localparam logic [17:0] AngularGainReset = 18'd65536;
	localparam logic [15:0] RateDbReset     = 16'd655;
	localparam logic [15:0] SpeedDbReset    = 16'd66;

	typedef enum logic [1:0] {
		REG_LINEAR_GAIN  = 2'd0,
		REG_ANGULAR_GAIN = 2'd1,
		REG_RATE_DB      = 2'd2,
		REG_SPEED_DB     = 2'd3
	} reg_idx_t;

	localparam logic CMD_WHEEL = 1'b0;
	localparam logic CMD_GYRO  = 1'b1;

	typedef struct packed {
		logic              cmd;
		logic signed [31:0] linear_speed;
		logic signed [19:0] angular_rate;
		logic [19:0]        elapsed_time;
	} in_item_t;

	typedef struct packed {
		logic signed [47:0] position_x;
		logic signed [47:0] position_y;
		logic signed [15:0] heading;
		logic signed [31:0] speed_out;
		logic signed [19:0] rate_out;
	} out_item_t;

	// multiplier handshake between sequencer and serial multiplier
	typedef struct packed {
		logic start;
		logic busy;
	} mul_ctl_t;

	// atan(2^-i), full turn = 2^32
	function automatic logic signed [31:0] atan_entry(input logic [4:0] i);
		case (i)
			5'd0:  atan_entry = 32'sd536870912;
			5'd1:  atan_entry = 32'sd316933406;
			5'd2:  atan_entry = 32'sd167458907;
			5'd3:  atan_entry = 32'sd85004756;
			5'd4:  atan_entry = 32'sd42667331;
			5'd5:  atan_entry = 32'sd21354465;
			5'd6:  atan_entry = 32'sd10679838;
			5'd7:  atan_entry = 32'sd5340245;
			5'd8:  atan_entry = 32'sd2670163;
			5'd9:  atan_entry = 32'sd1335087;
			5'd10: atan_entry = 32'sd667544;
			5'd11: atan_entry = 32'sd333772;
			5'd12: atan_entry = 32'sd166886;
			5'd13: atan_entry = 32'sd83443;
			5'd14: atan_entry = 32'sd41722;
			5'd15: atan_entry = 32'sd20861;
			5'd16: atan_entry = 32'sd10430;
			5'd17: atan_entry = 32'sd5215;
			5'd18: atan_entry = 32'sd2608;
			5'd19: atan_entry = 32'sd1304;
			5'd20: atan_entry = 32'sd652;
			5'd21: atan_entry = 32'sd326;
			5'd22: atan_entry = 32'sd163;
			5'd23: atan_entry = 32'sd81;
			default: atan_entry = 32'sd0;
		endcase
	endfunction
endpackage

// ----- sv/poi_if.sv -----
// poi_if: valid/ready request channel carrying a packed payload.
// Depends on nothing; payload width is a parameter.
interface poi_if #(parameter int W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/planar_odometry_integrator.sv -----
// planar_odometry_integrator: dead-reckoning pose integrator (top level).
// Depends on poi_pkg, poi_if, poi_cordic and poi_mul.
//
// Usage: items arrive on in_ch (cmd, linear_speed, angular_rate,
// elapsed_time); results leave on out_ch. A wheel item (cmd 0) stores the
// speed and emits nothing; wheel items can follow back to back.
// A gyro item emits one pose.
// The first gyro item after reset zeroes the pose; it goes from ST_OUT
// into the output register once that register is free.
// Later gyro items run a CORDIC, then nine products on one shared radix-4
// serial multiplier; the pose then goes from ST_OUT into the output
// register, and the next request is taken once the block is back in ST_IDLE.
// The pose sits in an output register. While it waits the block still takes
// the next request; a gyro item then holds in its last step until the
// receiver takes the earlier pose, so a stalled receiver stalls the input.
// Reset clears the pose, stored speed, started flag and loads register
// defaults; no clearing pass is needed.
// Configuration: cfg_we, cfg_idx (0..3), cfg_data (18 bits).
module planar_odometry_integrator #(
	parameter int CORDIC_STEPS  = poi_pkg::CordicStepsDefault,
	parameter int FRACTION_BITS = poi_pkg::FractionBitsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [17:0] cfg_data,
	poi_if.sink         in_ch,
	poi_if.source       out_ch
);
	localparam logic signed [47:0] PosMax = {1'b0, {47{1'b1}}};
	localparam logic signed [47:0] PosMin = {1'b1, 47'd0};

	typedef enum logic [3:0] {
		ST_IDLE, ST_CORDIC, ST_MUL, ST_WAIT, ST_OUT
	} state_t;

	state_t state_q;
	logic [17:0] lgain_q, again_q;
	logic [15:0] rdb_q, sdb_q;
	logic signed [31:0] speed_q;
	logic signed [47:0] px_q, py_q;
	logic signed [15:0] yaw_q;
	logic started_q;
	logic signed [19:0] rate_q;
	logic [19:0] dt_q;
	logic [3:0] op_q;
	logic signed [63:0] t_x_q, t_y_q, d_q;
	logic out_valid_q;
	logic out_load;
	poi_pkg::out_item_t out_q;
	poi_pkg::in_item_t  in_item;

	logic mstart;
	logic signed [63:0] ma, mb;
	logic signed [127:0] mp;
	poi_pkg::mul_ctl_t mctl;
	logic cstart, cbusy;
	logic signed [35:0] cval, sval;

	assign in_item = in_ch.data;

	poi_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .FRACTION_BITS(FRACTION_BITS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cstart), .angle(yaw_q),
		.busy(cbusy), .cos_o(cval), .sin_o(sval));

	poi_mul u_mul (.clk(clk), .arst_n(arst_n), .start(mstart), .a(ma), .b(mb),
		.ctl(mctl), .p(mp));

	function automatic logic signed [63:0] rnd(input logic signed [127:0] v,
			input int s);
		logic signed [127:0] t;
		t = (v + (128'sd1 <<< (s - 1))) >>> s;
		return t[63:0];
	endfunction

	function automatic logic signed [47:0] sat(input logic signed [63:0] v);
		if (v > 64'(PosMax)) return PosMax;
		if (v < 64'(PosMin)) return PosMin;
		return v[47:0];
	endfunction

	// operand selection per product step
	always_comb begin
		ma = '0;
		mb = '0;
		case (op_q)
			4'd0: begin ma = 64'(speed_q); mb = 64'(cval); end
			4'd1: begin ma = 64'(speed_q); mb = 64'(sval); end
			4'd2: begin ma = t_x_q; mb = 64'(dt_q); end
			4'd3: begin ma = t_y_q; mb = 64'(dt_q); end
			4'd4: begin ma = t_x_q; mb = 64'(lgain_q); end
			4'd5: begin ma = t_y_q; mb = 64'(lgain_q); end
			4'd6: begin ma = 64'(rate_q); mb = 64'(dt_q); end
			4'd7: begin ma = d_q; mb = 64'(again_q); end
			4'd8: begin ma = d_q; mb = 64'(poi_pkg::RadToBam); end
			default: ;
		endcase
	end

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;
	assign mstart = (state_q == ST_MUL);
	assign cstart = (state_q == ST_IDLE) && in_ch.valid && in_ch.ready
		&& (in_item.cmd == poi_pkg::CMD_GYRO) && started_q;
	// output register free, or freed at this edge
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ch.ready);

	logic signed [19:0] rate_db;
	logic signed [31:0] speed_db;
	always_comb begin
		rate_db  = ((in_item.angular_rate < $signed({4'd0, rdb_q}))
			&& (in_item.angular_rate > -$signed({4'd0, rdb_q})))
			? '0 : in_item.angular_rate;
		speed_db = ((speed_q < $signed({16'd0, sdb_q}))
			&& (speed_q > -$signed({16'd0, sdb_q}))) ? '0 : speed_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lgain_q     <= poi_pkg::LinearGainReset;
			again_q     <= poi_pkg::AngularGainReset;
			rdb_q       <= poi_pkg::RateDbReset;
			sdb_q       <= poi_pkg::SpeedDbReset;
			speed_q     <= '0;
			px_q        <= '0;
			py_q        <= '0;
			yaw_q       <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
			op_q        <= '0;
		end else begin
			if (cfg_we) begin
				case (poi_pkg::reg_idx_t'(cfg_idx))
					poi_pkg::REG_LINEAR_GAIN:  lgain_q <= cfg_data;
					poi_pkg::REG_ANGULAR_GAIN: again_q <= cfg_data;
					poi_pkg::REG_RATE_DB:      rdb_q   <= cfg_data[15:0];
					poi_pkg::REG_SPEED_DB:     sdb_q   <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ch.valid && out_ch.ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						if (in_item.cmd == poi_pkg::CMD_WHEEL) begin
							speed_q <= in_item.linear_speed;
						end else if (!started_q) begin
							started_q <= 1'b1;
							speed_q <= '0; px_q <= '0; py_q <= '0; yaw_q <= '0;
							rate_q <= '0;
							state_q <= ST_OUT;
						end else begin
							rate_q  <= rate_db;
							speed_q <= speed_db;
							dt_q    <= in_item.elapsed_time;
							op_q    <= '0;
							state_q <= ST_CORDIC;
						end
					end
				end
				ST_CORDIC: if (!cbusy) state_q <= ST_MUL;
				ST_MUL: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (!mctl.busy && !mctl.start) begin
						case (op_q)
							4'd0: t_x_q <= rnd(mp, FRACTION_BITS);
							4'd1: t_y_q <= rnd(mp, FRACTION_BITS);
							4'd2: t_x_q <= rnd(mp, 20);
							4'd3: t_y_q <= rnd(mp, 20);
							4'd4: px_q <= sat(64'(px_q) + rnd(mp, 16));
							4'd5: py_q <= sat(64'(py_q) + rnd(mp, 16));
							4'd6: d_q <= mp[63:0];
							4'd7: d_q <= rnd(mp, 36);
							4'd8: yaw_q <= yaw_q + 16'(rnd(mp, 32));
							default: ;
						endcase
						op_q <= op_q + 4'd1;
						state_q <= (op_q == 4'd8) ? ST_OUT : ST_MUL;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						out_q <= '{position_x: px_q, position_y: py_q, heading: yaw_q,
							speed_out: speed_q, rate_out: rate_q};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ch.ready)
		else $error("item accepted while busy");
	a_out_after_calc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |=> out_valid_q)
		else $error("result not presented");
	a_cordic_start: assert property (@(posedge clk) disable iff (!arst_n)
		cstart |=> (state_q == ST_CORDIC))
		else $error("cordic started outside gyro path");
endmodule

// ----- sv/poi_mul.sv -----
// poi_mul: radix-4 serial signed multiplier, 64x64 -> 128, two bits a cycle.
// Depends on poi_pkg.
module poi_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [63:0]  a,
	input  logic signed [63:0]  b,
	output poi_pkg::mul_ctl_t   ctl,
	output logic signed [127:0] p
);
	logic [127:0] acc_q;
	logic [63:0]  mb_q;
	logic [127:0] mc_q;
	logic [5:0]   cnt_q;
	logic         busy_q;
	logic [127:0] addend;

	// unsigned multiply of magnitudes, sign fixed at the end
	always_comb begin
		addend = '0;
		if (mb_q[0]) addend = addend + mc_q;
		if (mb_q[1]) addend = addend + {mc_q[126:0], 1'b0};
	end

	logic neg_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd31;
			acc_q  <= '0;
			mb_q   <= b[63] ? 64'(-b) : 64'(b);
			mc_q   <= {64'd0, (a[63] ? 64'(-a) : 64'(a))};
			neg_q  <= a[63] ^ b[63];
		end else if (busy_q) begin
			acc_q <= acc_q + addend;
			mb_q  <= {2'b00, mb_q[63:2]};
			mc_q  <= {mc_q[125:0], 2'b00};
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd0) busy_q <= 1'b0;
		end
	end

	assign ctl.start = start;
	assign ctl.busy  = busy_q;
	assign p = neg_q ? -$signed(acc_q) : $signed(acc_q);
endmodule

// ----- sv/poi_cordic.sv -----
// poi_cordic: iterative rotation CORDIC, one micro-rotation a cycle.
// Depends on poi_pkg.
module poi_cordic #(
	parameter int CORDIC_STEPS  = poi_pkg::CordicStepsDefault,
	parameter int FRACTION_BITS = poi_pkg::FractionBitsDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [15:0] angle,
	output logic               busy,
	output logic signed [35:0] cos_o,
	output logic signed [35:0] sin_o
);
	localparam int Steps = (CORDIC_STEPS < poi_pkg::TableLen) ? CORDIC_STEPS
		: poi_pkg::TableLen;
	localparam int Sh = 30 - FRACTION_BITS;

	logic signed [35:0] x_q, y_q;
	logic signed [33:0] z_q;
	logic [4:0]         i_q;
	logic               busy_q, flip_q;
	logic signed [15:0] a_adj;
	logic               flip;
	logic signed [35:0] xs, ys, xr, yr;

	always_comb begin
		flip  = (angle > 16'sd16384) || (angle < -16'sd16384);
		a_adj = flip ? angle + 16'sh8000 : angle;
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		xr = (x_q + (36'sd1 <<< (Sh - 1))) >>> Sh;
		yr = (y_q + (36'sd1 <<< (Sh - 1))) >>> Sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			i_q    <= '0;
			flip_q <= flip;
			x_q    <= 36'(poi_pkg::CordicK);
			y_q    <= '0;
			z_q    <= 34'(a_adj) <<< 16;
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - 34'(poi_pkg::atan_entry(i_q));
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + 34'(poi_pkg::atan_entry(i_q));
			end
			i_q <= i_q + 5'd1;
			if (i_q == 5'(Steps - 1)) busy_q <= 1'b0;
		end
	end

	assign busy  = busy_q;
	assign cos_o = flip_q ? -xr : xr;
	assign sin_o = flip_q ? -yr : yr;
endmodule

// ----- bench/poi_checker.sv -----
`timescale 1ns / 100ps
// poi_checker: watches the request and pose channels of the odometry integrator,
// predicts every pose and compares it field by field. Depends on poi_pkg.
module poi_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [17:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  poi_pkg::in_item_t  in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  poi_pkg::out_item_t out_data,
	output int          errors,
	output int          pending,
	output int          poses_seen
);
	localparam int Steps = poi_pkg::CordicStepsDefault;
	localparam int Frac  = poi_pkg::FractionBitsDefault;
	localparam longint PosMax = 64'sd140737488355327;
	localparam longint PosMin = -64'sd140737488355328;

	const longint atan_turn[poi_pkg::TableLen] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
	};

	longint lin_gain, ang_gain, rate_db, speed_db;
	longint speed_q, x_q, y_q, yaw_q;
	bit     have_gyro;
	poi_pkg::out_item_t pose_q[$];

	function automatic longint round_shift(longint v, int s);
		if (s == 0)
			return v;
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint wrap16(longint v);
		logic signed [15:0] t;
		t = v[15:0];
		return t;
	endfunction

	function automatic longint clip_db(longint v, longint db);
		return (v < db && v > -db) ? 64'sd0 : v;
	endfunction

	function automatic longint clamp_pos(longint v);
		if (v > PosMax) return PosMax;
		if (v < PosMin) return PosMin;
		return v;
	endfunction

	// rotation-mode CORDIC on a binary angle, folded into the right half plane
	task automatic rotate(input longint ang, output longint c, output longint s);
		longint x, y, z, nx;
		bit flip;
		flip = 0;
		x = poi_pkg::CordicK;
		y = 0;
		if (ang > 16384 || ang < -16384) begin
			flip = 1;
			ang = wrap16(ang + 32768);
		end
		z = ang * 65536;
		for (int i = 0; i < Steps && i < poi_pkg::TableLen; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y  = y + (x >>> i);
				z  = z - atan_turn[i];
			end else begin
				nx = x + (y >>> i);
				y  = y - (x >>> i);
				z  = z + atan_turn[i];
			end
			x = nx;
		end
		x = round_shift(x, 30 - Frac);
		y = round_shift(y, 30 - Frac);
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	function automatic longint travel(longint spd, longint trig, longint dt, longint g);
		longint p;
		p = round_shift(spd * trig, Frac);
		p = round_shift(p * dt, 20);
		return round_shift(p * g, 16);
	endfunction

	task automatic predict_gyro(input poi_pkg::in_item_t it);
		longint rate, dt, c, s, d, bam;
		poi_pkg::out_item_t o;
		rate = it.angular_rate;
		rate = clip_db(rate, rate_db);
		speed_q = clip_db(speed_q, speed_db);
		dt = {44'd0, it.elapsed_time};
		if (!have_gyro) begin
			have_gyro = 1;
			rate = 0;
			speed_q = 0;
			x_q = 0;
			y_q = 0;
			yaw_q = 0;
		end else begin
			rotate(yaw_q, c, s);
			x_q = clamp_pos(x_q + travel(speed_q, c, dt, lin_gain));
			y_q = clamp_pos(y_q + travel(speed_q, s, dt, lin_gain));
			d = round_shift(rate * dt * ang_gain, 36);
			bam = round_shift(d * longint'(poi_pkg::RadToBam), 32);
			yaw_q = wrap16(yaw_q + bam);
		end
		o.position_x = x_q[47:0];
		o.position_y = y_q[47:0];
		o.heading    = yaw_q[15:0];
		o.speed_out  = speed_q[31:0];
		o.rate_out   = rate[19:0];
		pose_q.push_back(o);
	endtask

	task automatic compare_pose(input poi_pkg::out_item_t got);
		poi_pkg::out_item_t want;
		if (pose_q.size() == 0) begin
			errors++;
			$error("pose with no request outstanding");
			return;
		end
		want = pose_q.pop_front();
		if (got.position_x !== want.position_x) begin
			errors++;
			$error("position_x expected %0d got %0d", want.position_x, got.position_x);
		end
		if (got.position_y !== want.position_y) begin
			errors++;
			$error("position_y expected %0d got %0d", want.position_y, got.position_y);
		end
		if (got.heading !== want.heading) begin
			errors++;
			$error("heading expected %0d got %0d", want.heading, got.heading);
		end
		if (got.speed_out !== want.speed_out) begin
			errors++;
			$error("speed_out expected %0d got %0d", want.speed_out, got.speed_out);
		end
		if (got.rate_out !== want.rate_out) begin
			errors++;
			$error("rate_out expected %0d got %0d", want.rate_out, got.rate_out);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_gain   = poi_pkg::LinearGainReset;
			ang_gain   = poi_pkg::AngularGainReset;
			rate_db    = poi_pkg::RateDbReset;
			speed_db   = poi_pkg::SpeedDbReset;
			speed_q    = 0;
			x_q        = 0;
			y_q        = 0;
			yaw_q      = 0;
			have_gyro  = 0;
			errors     = 0;
			poses_seen = 0;
			pose_q.delete();
		end else begin
			if (cfg_we) begin
				case (poi_pkg::reg_idx_t'(cfg_idx))
					poi_pkg::REG_LINEAR_GAIN:  lin_gain = cfg_data;
					poi_pkg::REG_ANGULAR_GAIN: ang_gain = cfg_data;
					poi_pkg::REG_RATE_DB:      rate_db  = cfg_data[15:0];
					poi_pkg::REG_SPEED_DB:     speed_db = cfg_data[15:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (in_data.cmd == poi_pkg::CMD_WHEEL)
					speed_q = in_data.linear_speed;
				else
					predict_gyro(in_data);
			end
			if (out_valid && out_ready) begin
				poses_seen++;
				compare_pose(out_data);
			end
		end
		pending = pose_q.size();
	end
endmodule

// ----- bench/planar_odometry_integrator_tb.sv -----
`timescale 1ns / 100ps
// planar_odometry_integrator_tb: drives wheel and gyro requests and register
// settings into the integrator; poi_checker predicts and compares the poses.
module planar_odometry_integrator_tb;
	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_idx;
	logic [17:0] cfg_data;
	int          errors, pending, poses_seen;
	int          sent, settings;
	bit          quiet, long_hold;

	poi_if #(.W($bits(poi_pkg::in_item_t)))  in_ch ();
	poi_if #(.W($bits(poi_pkg::out_item_t))) out_ch ();

	planar_odometry_integrator dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	poi_checker pose_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
		.errors(errors), .pending(pending), .poses_seen(poses_seen)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

	// pose receiver: random stall bursts, one long hold on request
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_ch.ready <= 1'b0;
				repeat (600) @(posedge clk);
				long_hold = 0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send(input poi_pkg::in_item_t it);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= it;
		do @(posedge clk); while (!in_ch.ready);
		sent++;
	endtask

	function automatic poi_pkg::in_item_t wheel(input logic signed [31:0] spd);
		poi_pkg::in_item_t it;
		it = '0;
		it.cmd = poi_pkg::CMD_WHEEL;
		it.linear_speed = spd;
		it.angular_rate = 20'($urandom);
		it.elapsed_time = 20'($urandom);
		return it;
	endfunction

	function automatic poi_pkg::in_item_t gyro(input logic signed [19:0] rate,
			input logic [19:0] dt);
		poi_pkg::in_item_t it;
		it.cmd = poi_pkg::CMD_GYRO;
		it.linear_speed = $urandom;
		it.angular_rate = rate;
		it.elapsed_time = dt;
		return it;
	endfunction

	function automatic poi_pkg::in_item_t random_request();
		logic signed [31:0] spd;
		logic signed [19:0] rate;
		logic [19:0] dt;
		case ($urandom_range(0, 3))
			0: spd = $urandom;
			1: spd = $signed($urandom_range(0, 400)) - 200;
			default: spd = $signed($urandom_range(0, 2 * 65536 * 8)) - 65536 * 8;
		endcase
		case ($urandom_range(0, 3))
			0: rate = 20'($urandom);
			1: rate = 20'(int'($urandom_range(0, 2000)) - 1000);
			default: rate = 20'(int'($urandom_range(0, 131072)) - 65536);
		endcase
		dt = ($urandom_range(0, 2) == 0) ? 20'($urandom) : 20'($urandom_range(0, 65536));
		return ($urandom_range(0, 1) == 0) ? wheel(spd) : gyro(rate, dt);
	endfunction

	// the checker counts a request at its accepting edge, so look from the next edge on
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(input poi_pkg::reg_idx_t idx, input logic [17:0] val);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we   <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [17:0] lg, ag, input logic [15:0] rdb, sdb);
		drain();
		write_reg(poi_pkg::REG_LINEAR_GAIN, lg);
		write_reg(poi_pkg::REG_ANGULAR_GAIN, ag);
		write_reg(poi_pkg::REG_RATE_DB, {2'b0, rdb});
		write_reg(poi_pkg::REG_SPEED_DB, {2'b0, sdb});
		settings++;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		quiet = 0;
		long_hold = 0;
		sent = 0;
		settings = 1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: first gyro zeroes everything, then extremes and deadband edges
		send(wheel(32'sd655360));
		send(gyro(20'sd300000, 20'hFFFFF));
		send(wheel(32'sh7FFFFFFF));
		send(gyro(20'sd524287, 20'hFFFFF));
		send(gyro(-20'sd524288, 20'hFFFFF));
		send(gyro(20'sd655, 20'd0));
		send(gyro(20'sd654, 20'd1000));
		send(gyro(-20'sd655, 20'd1000));
		send(gyro(-20'sd654, 20'd1000));
		send(wheel(-32'sh80000000));
		send(gyro(20'sd400000, 20'hFFFFF));
		send(wheel(32'sd66));
		send(gyro(20'sd0, 20'd50000));
		send(wheel(32'sd65));
		send(gyro(20'sd0, 20'd50000));
		send(wheel(-32'sd66));
		send(gyro(20'sd0, 20'd50000));
		send(wheel(-32'sd65));
		send(gyro(20'sd0, 20'd50000));
		// drive heading across +pi
		send(wheel(32'sd131072));
		repeat (4) send(gyro(20'sd524287, 20'hFFFFF));

		configure(18'd0, 18'd262143, 16'd0, 16'd0);
		repeat (180) send(random_request());
		configure(18'd262143, 18'd0, 16'd65535, 16'd65535);
		repeat (180) send(random_request());
		configure(18'($urandom), 18'($urandom), 16'($urandom_range(0, 4000)),
			16'($urandom_range(0, 4000)));
		for (int i = 0; i < 200; i++) begin
			if (i == 40) begin
				long_hold = 1;
				repeat (3) send(random_request());
			end
			if (i == 120)
				drain();
			send(random_request());
		end
		configure(18'd65536, 18'd65536, 16'd655, 16'd66);
		repeat (200) send(random_request());
		quiet = 1;
		repeat (170) send(random_request());

		drain();
		$display("Sent %0d wheel and gyro requests over %0d register settings,",
			sent, settings);
		$display("%0d poses compared against the predicted pose", poses_seen);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
